// File: sv/refcount_block_allocator_assert.svh
// Assertion macros for the checker of the refcount block allocator.
// Needs nothing else; included by the checker file.
`ifndef REFCOUNT_BLOCK_ALLOCATOR_ASSERT_SVH
`define REFCOUNT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define RCBA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RCBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rcba_pkg.sv
// Types and constants of the refcount block allocator.
// No dependencies; imported by the top level and the checker.
package rcba_pkg;

  localparam int unsigned BLOCK_BYTES_DEF   = 256;
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  localparam int unsigned LEN_W = 21;
  localparam int unsigned OFF_W = 20;
  localparam int unsigned REF_W = 16;

  typedef enum logic [1:0] {
    OP_ALLOC_FIRST = 2'd0,
    OP_ALLOC_FAST  = 2'd1,
    OP_FREE        = 2'd2,
    OP_INCR        = 2'd3
  } op_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    op_e              opcode;
    logic [LEN_W-1:0] byte_length;
    logic [OFF_W-1:0] byte_offset;
    logic [REF_W-1:0] ref_amount;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] alloc_offset;
  } rsp_t;

endpackage

// File: sv/rcba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the reference count table.
module rcba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/refcount_block_allocator.sv
// Top level of the refcount block allocator: sequencer, shared reciprocal multiplier, table RAM.
// Depends on rcba_pkg and rcba_ram.
//
//  channel   signals                     direction  beat taken when
//  request   start, busy, req_i          in         start && !busy at clk edge
//  result    rsp_valid_o, rsp_o          out        rsp_valid_o high (one cycle only)
//
// Steps: every request first passes the shared reciprocal multiplier, which
// works out the block count. Free and increment also pass it for the start
// block and then do a RAM read and a write back per block.
// First-fit scans the used table at one entry a cycle through the single read
// port and falls back to an append when no run is found. An append does a room
// check first. A fill writes one entry a cycle, then works out the offset.
// The result strobe comes in the cycle after the last step, busy drops with it.
// Reset clears only the control state, the used count and the result; the table
// holds nothing valid until written and needs no clearing. The receiver cannot stall.
module refcount_block_allocator
  import rcba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES   = BLOCK_BYTES_DEF,
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);     // table address
  localparam int unsigned UW  = $clog2(TABLE_ENTRIES + 1); // used count
  localparam int unsigned PW  = AW + 17;                   // offset product
  localparam int unsigned IW  = LEN_W + 1;                 // walking index
  localparam int unsigned DW  = LEN_W + 1;                 // dividend: length rounded up, or offset
  localparam int unsigned MW  = DW + 1;                    // reciprocal
  localparam int unsigned LW  = $clog2(BLOCK_BYTES);
  localparam int unsigned SH  = DW + LW;                   // reciprocal scale
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [MW-1:0]  RECIP_C  = MW'(RECIP);
  localparam logic [DW-1:0]  BB_M1    = DW'(BLOCK_BYTES - 1);
  localparam logic [IW-1:0]  TE_C     = IW'(TABLE_ENTRIES);
  localparam logic [PW-1:0]  BB_P     = PW'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LEN,
    S_DIV_OFF,
    S_SCAN,
    S_APPEND,
    S_FILL,
    S_RMW_RD,
    S_RMW_WR,
    S_OFFS
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [REF_W-1:0] amt_q, amt_d;
  logic [OFF_W-1:0] boff_q, boff_d;
  logic [DW-1:0]    dq_q, dq_d;     // dividend for the shared multiplier
  logic [LEN_W-1:0] n_q, n_d;       // blocks in the request
  logic [LEN_W-1:0] left_q, left_d; // blocks still to touch
  logic [IW-1:0]    cur_q, cur_d;   // current table index
  logic [UW-1:0]    scan_q, scan_d;
  logic [AW-1:0]    evl_q, evl_d;   // index whose read is in flight
  logic             dvld_q, dvld_d;
  logic [UW-1:0]    run_q, run_d;
  logic [AW-1:0]    start_q, start_d;
  logic [UW-1:0]    used_q, used_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_vld_q, rsp_vld_d;

  // RAM side
  logic             ram_we;
  logic [REF_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [REF_W-1:0] ram_rdata;

  // shared divide by the block size: multiply by the scaled reciprocal, shift
  logic [DW+MW-1:0] div_prod;
  logic [DW+MW-1:0] div_sh;
  logic [DW-1:0]    div_q;
  logic [LEN_W-1:0] n_fin;

  logic             zero_hit;
  logic [UW-1:0]    run_nx;
  logic             scan_hit;
  logic [IW-1:0]    free_cnt;
  logic [IW-1:0]    used_sum;
  logic [IW-1:0]    start_dif;
  logic [REF_W-1:0] rmw_val;
  logic [PW-1:0]    prod;

  // exact for every dividend below 2^DW
  assign div_prod = (DW+MW)'(dq_q) * (DW+MW)'(RECIP_C);
  assign div_sh   = div_prod >> SH;
  assign div_q    = div_sh[DW-1:0];
  assign n_fin    = div_q[LEN_W-1:0];

  assign zero_hit  = (ram_rdata == '0);
  assign run_nx    = zero_hit ? (run_q + UW'(1)) : '0;
  assign scan_hit  = dvld_q && zero_hit && ((IW'(run_q) + IW'(1)) == IW'(n_q));
  assign start_dif = IW'(evl_q) - IW'(run_q);
  assign free_cnt  = TE_C - IW'(used_q);
  assign used_sum  = IW'(used_q) + IW'(n_q);

  always_comb begin
    if (op_q == OP_FREE) begin
      rmw_val = (amt_q > ram_rdata) ? '0 : (ram_rdata - amt_q);
    end else begin
      rmw_val = ram_rdata + amt_q;
    end
  end

  assign prod = PW'(start_q) * BB_P;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    amt_d     = amt_q;
    boff_d    = boff_q;
    dq_d      = dq_q;
    n_d       = n_q;
    left_d    = left_q;
    cur_d     = cur_q;
    scan_d    = scan_q;
    evl_d     = evl_q;
    dvld_d    = dvld_q;
    run_d     = run_q;
    start_d   = start_q;
    used_d    = used_q;
    rsp_d     = rsp_q;
    rsp_vld_d = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = amt_q;
    ram_raddr = (state_q == S_SCAN) ? scan_q[AW-1:0] : cur_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = req_i.opcode;
          amt_d   = req_i.ref_amount;
          boff_d  = req_i.byte_offset;
          // round up: length plus one block less a byte
          dq_d    = DW'(req_i.byte_length) + BB_M1;
          state_d = S_DIV_LEN;
        end
      end

      S_DIV_LEN: begin
        n_d = n_fin;
        if (n_fin == '0) begin
          // zero length: nothing to do
          rsp_d     = '{status: STATUS_OK, alloc_offset: '0};
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          unique case (op_q)
            OP_ALLOC_FIRST: begin
              scan_d  = '0;
              run_d   = '0;
              dvld_d  = 1'b0;
              state_d = S_SCAN;
            end
            OP_ALLOC_FAST: begin
              state_d = S_APPEND;
            end
            OP_FREE, OP_INCR: begin
              dq_d    = DW'(boff_q);
              state_d = S_DIV_OFF;
            end
          endcase
        end
      end

      S_DIV_OFF: begin
        cur_d   = IW'(div_q);
        left_d  = n_q;
        state_d = S_RMW_RD;
      end

      S_SCAN: begin
        // reads go out one a cycle; data is judged in the next cycle
        if (dvld_q) begin
          run_d = run_nx;
        end
        if (scan_hit) begin
          start_d = start_dif[AW-1:0];
          cur_d   = start_dif;
          left_d  = n_q;
          dvld_d  = 1'b0;
          state_d = S_FILL;
        end else if (scan_q < used_q) begin
          dvld_d = 1'b1;
          evl_d  = scan_q[AW-1:0];
          scan_d = scan_q + UW'(1);
        end else begin
          dvld_d = 1'b0;
          if (!dvld_q) begin
            state_d = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        if (IW'(n_q) > free_cnt) begin
          // not enough free entries: rejected whole
          rsp_d     = '{status: STATUS_ERR, alloc_offset: '0};
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          start_d = used_q[AW-1:0];
          cur_d   = IW'(used_q);
          left_d  = n_q;
          used_d  = used_sum[UW-1:0];
          state_d = S_FILL;
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = amt_q;
        cur_d     = cur_q + IW'(1);
        left_d    = left_q - LEN_W'(1);
        if (left_q == LEN_W'(1)) begin
          state_d = S_OFFS;
        end
      end

      S_OFFS: begin
        rsp_d     = '{status: STATUS_OK, alloc_offset: prod[OFF_W-1:0]};
        rsp_vld_d = 1'b1;
        state_d   = S_IDLE;
      end

      S_RMW_RD: begin
        if (cur_q >= IW'(used_q)) begin
          // ran past the used part; earlier blocks stay updated
          rsp_d     = '{status: STATUS_ERR, alloc_offset: '0};
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_RMW_WR;
        end
      end

      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rmw_val;
        cur_d     = cur_q + IW'(1);
        left_d    = left_q - LEN_W'(1);
        if (left_q == LEN_W'(1)) begin
          rsp_d     = '{status: STATUS_OK, alloc_offset: '0};
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_RMW_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      dvld_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      dvld_q    <= dvld_d;
      rsp_vld_q <= rsp_vld_d;
      rsp_q     <= rsp_d;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    amt_q   <= amt_d;
    boff_q  <= boff_d;
    dq_q    <= dq_d;
    n_q     <= n_d;
    left_q  <= left_d;
    cur_q   <= cur_d;
    scan_q  <= scan_d;
    evl_q   <= evl_d;
    run_q   <= run_d;
    start_q <= start_d;
  end

  rcba_ram #(
    .WIDTH(REF_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

// File: sv/rcba_checker.sv
// Port-level checker for the refcount block allocator, bound to the top level.
// Depends on rcba_pkg and refcount_block_allocator_assert.svh.
`include "refcount_block_allocator_assert.svh"

module rcba_checker
  import rcba_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // an accepted beat makes the block busy in the next cycle
  `RCBA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")

  // the result strobe comes only as the work finishes
  `RCBA_ASSERT_NOW(a_strobe_idle, clk_i, rst_ni, rsp_valid_o, !busy && $past(busy), "stray strobe")

  // every finished request leaves one result
  `RCBA_ASSERT_NOW(a_done_strobe, clk_i, rst_ni, $fell(busy), rsp_valid_o, "result lost")

  // failures carry no offset
  `RCBA_ASSERT_NOW(a_err_offset, clk_i, rst_ni, rsp_valid_o && rsp_o.status, rsp_o.alloc_offset == '0, "error with offset")

endmodule

bind refcount_block_allocator rcba_checker u_rcba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .rsp_valid_o(rsp_valid_o),
  .rsp_o      (rsp_o)
);
